@@ sv/cleb_pkg.sv @@
// Shared constants and types for the cursor line edit buffer.
`timescale 1ns / 1ps

package cleb_pkg;

    localparam int LINE_CAP = 1024;
    localparam int ADDR_W   = $clog2(LINE_CAP);
    localparam int PTR_W    = ADDR_W + 1;

    localparam logic [PTR_W-1:0] CAP_PTR = PTR_W'(LINE_CAP);

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } cleb_mem_req_t;

endpackage

@@ sv/cleb_if.sv @@
// Handshake channels for key/read items and result items.
`timescale 1ns / 1ps

interface cleb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink (input valid, input func, input key, output ready);
endinterface

interface cleb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_char;
    logic [1:0] status;

    modport source (output valid, output out_char, output char_valid, output last_char,
                    output status, input ready);
    modport sink (input valid, input out_char, input char_valid, input last_char,
                  input status, output ready);
endinterface

@@ sv/cursor_line_edit_buffer_top.sv @@
// An item is taken in the idle state, then passes the execute state and the done state.
// Real cursor moves and non-empty reads add a memory wait state for the registered text store read.
// The done state waits for a free output register, registers the result and returns to idle.
// A new item is taken while the previous result still waits in the output register.
// Reset (async, active low) empties the text and clears the result; store contents stay undefined.
`timescale 1ns / 1ps

module cursor_line_edit_buffer_top
    import cleb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cleb_in_if.sink    keys,
    cleb_out_if.source result
);

    cleb_mem_req_t mem_req;
    logic [7:0]    mem_rdata;

    cleb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    cleb_text_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

@@ sv/cleb_text_ram.sv @@
// Text store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module cleb_text_ram
    import cleb_pkg::*;
(
    input  logic          clk,
    input  cleb_mem_req_t req,
    output logic [7:0]    rdata
);

    logic [7:0] mem [LINE_CAP];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/cleb_ctrl.sv @@
// Gap pointers, read position and the sequencer that edits the text store.
`timescale 1ns / 1ps

module cleb_ctrl
    import cleb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cleb_in_if.sink       keys,
    cleb_out_if.source    result,
    output cleb_mem_req_t mem_req,
    input  logic [7:0]    mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEMWAIT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic              func_reg, func_next;
    logic [7:0]        key_reg, key_next;
    logic [PTR_W-1:0]  gs_reg, gs_next;
    logic [PTR_W-1:0]  ge_reg, ge_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic              rcv_reg, rcv_next;
    logic              rlast_reg, rlast_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic              ocv_reg, ocv_next;
    logic              olast_reg, olast_next;
    logic [1:0]        ostat_reg, ostat_next;

    logic [PTR_W-1:0]  text_len;
    logic [PTR_W-1:0]  rp_eff;
    logic [PTR_W-1:0]  phys;
    logic [PTR_W-1:0]  gs_dec;
    logic [PTR_W-1:0]  ge_dec;
    logic [PTR_W-1:0]  rp_inc;

    assign text_len = gs_reg + (CAP_PTR - ge_reg);
    assign rp_eff   = (rp_reg >= text_len) ? '0 : rp_reg;
    assign phys     = (rp_eff < gs_reg) ? rp_eff : rp_eff + (ge_reg - gs_reg);
    assign gs_dec   = gs_reg - PTR_W'(1);
    assign ge_dec   = ge_reg - PTR_W'(1);
    assign rp_inc   = rp_reg + PTR_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        gs_next     = gs_reg;
        ge_next     = ge_reg;
        rp_next     = rp_reg;
        rchar_next  = rchar_reg;
        rcv_next    = rcv_reg;
        rlast_next  = rlast_reg;
        rstat_next  = rstat_reg;
        ovalid_next = ovalid_reg && !result.ready;
        ochar_next  = ochar_reg;
        ocv_next    = ocv_reg;
        olast_next  = olast_reg;
        ostat_next  = ostat_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (keys.valid)
                begin
                    func_next  = keys.func;
                    key_next   = keys.key;
                    rchar_next = '0;
                    rcv_next   = 1'b0;
                    rlast_next = 1'b0;
                    rstat_next = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                if (func_reg == FUNC_KEY)
                begin
                    rp_next = '0;
                    unique case (key_reg)
                        KEY_LEFT:
                        begin
                            if (gs_reg != '0)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = gs_dec[ADDR_W-1:0];
                                state_next    = S_MEMWAIT;
                            end
                        end
                        KEY_RIGHT:
                        begin
                            if (ge_reg != CAP_PTR)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ge_reg[ADDR_W-1:0];
                                state_next    = S_MEMWAIT;
                            end
                        end
                        KEY_BACK:
                        begin
                            if (gs_reg != '0)
                            begin
                                gs_next = gs_dec;
                            end
                        end
                        default:
                        begin
                            if (gs_reg >= ge_reg)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = gs_reg[ADDR_W-1:0];
                                mem_req.wdata = key_reg;
                                gs_next       = gs_reg + PTR_W'(1);
                            end
                        end
                    endcase
                end
                else if (text_len == '0)
                begin
                    rstat_next = ST_EMPTY;
                end
                else
                begin
                    // Keep the wrapped position so the memory wait state counts on from it.
                    rp_next       = rp_eff;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = phys[ADDR_W-1:0];
                    state_next    = S_MEMWAIT;
                end
            end

            S_MEMWAIT:
            begin
                state_next = S_DONE;
                if (func_reg == FUNC_KEY)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = mem_rdata;
                    if (key_reg == KEY_LEFT)
                    begin
                        mem_req.waddr = ge_dec[ADDR_W-1:0];
                        gs_next       = gs_dec;
                        ge_next       = ge_dec;
                    end
                    else
                    begin
                        mem_req.waddr = gs_reg[ADDR_W-1:0];
                        gs_next       = gs_reg + PTR_W'(1);
                        ge_next       = ge_reg + PTR_W'(1);
                    end
                end
                else
                begin
                    rchar_next = mem_rdata;
                    rcv_next   = 1'b1;
                    rp_next    = rp_inc;
                    if (rp_inc == text_len)
                    begin
                        rlast_next = 1'b1;
                        gs_next    = '0;
                        ge_next    = CAP_PTR;
                        rp_next    = '0;
                    end
                end
            end

            S_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = rchar_reg;
                    ocv_next    = rcv_reg;
                    olast_next  = rlast_reg;
                    ostat_next  = rstat_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            func_reg   <= 1'b0;
            key_reg    <= '0;
            gs_reg     <= '0;
            ge_reg     <= CAP_PTR;
            rp_reg     <= '0;
            rchar_reg  <= '0;
            rcv_reg    <= 1'b0;
            rlast_reg  <= 1'b0;
            rstat_reg  <= ST_OK;
            ovalid_reg <= 1'b0;
            ochar_reg  <= '0;
            ocv_reg    <= 1'b0;
            olast_reg  <= 1'b0;
            ostat_reg  <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            key_reg    <= key_next;
            gs_reg     <= gs_next;
            ge_reg     <= ge_next;
            rp_reg     <= rp_next;
            rchar_reg  <= rchar_next;
            rcv_reg    <= rcv_next;
            rlast_reg  <= rlast_next;
            rstat_reg  <= rstat_next;
            ovalid_reg <= ovalid_next;
            ochar_reg  <= ochar_next;
            ocv_reg    <= ocv_next;
            olast_reg  <= olast_next;
            ostat_reg  <= ostat_next;
        end
    end

    assign keys.ready        = (state_reg == S_IDLE);
    assign result.valid      = ovalid_reg;
    assign result.out_char   = ochar_reg;
    assign result.char_valid = ocv_reg;
    assign result.last_char  = olast_reg;
    assign result.status     = ostat_reg;

endmodule

@@ sv/cleb_checker.sv @@
// Port-level checks on result items of the cursor line edit buffer.
`timescale 1ns / 1ps

module cleb_checker
    import cleb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       char_valid,
    input logic       last_char,
    input logic [1:0] status
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn while stalled");

    // The final character of the text is always a real character.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char |-> char_valid && status == ST_OK)
        else $error("last_char without a character");

    // An empty read carries no character.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> !char_valid && !last_char)
        else $error("empty read returned a character");

    // A dropped insert is a key item and never carries a character.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> !char_valid && !last_char)
        else $error("full status on a read result");

endmodule

bind cursor_line_edit_buffer_top cleb_checker u_cleb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .char_valid (result.char_valid),
    .last_char  (result.last_char),
    .status     (result.status)
);
